// File: rtl/stpr_pkg.sv
// ============================================================================
// stpr_pkg
// Shared types and constants for the stepper trapezoid ramp generator.
// ============================================================================
`default_nettype none

package stpr_pkg;

    localparam int MOVE_W        = 25;
    localparam int RAMP_MAX_W    = 24;
    localparam int MULT_W        = 32;
    localparam int START_PER_W   = 32;
    localparam int OUT_PERIOD_W  = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int DELTA_SHIFT   = 80;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS_MAX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_MULTIPLIER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_INVERT      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_APPLY,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/stepper_trapezoid_ramp.sv
// ============================================================================
// stepper_trapezoid_ramp
// One axis of a trapezoidal stepper speed ramp. A start transaction loads a
// move; each tick transaction issues a step and updates the step period with
// p' = p -/+ M*p^3 / 2^80, computed by a serial-parallel shift-add multiplier.
// ============================================================================
//
//  channel | ports                                 | direction
//  --------+---------------------------------------+----------
//  s_      | s_valid s_ready s_kind s_move_steps   | in
//  m_      | m_valid m_ready m_step_pulse ...      | out
//  cfg_    | cfg_wr_en cfg_wr_index cfg_wr_data    | in
//
//  Start, idle or cruise tick: accept, then CALC and EMIT into the result register.
//  Ramp tick: CALC, then three passes of the one-bit-per-cycle
//  multiplier forming M*P*P*P (MUL1..MUL3), then APPLY and EMIT.
//  One transaction in flight; the next is accepted while a result waits.
//  Reset is synchronous; no clearing pass is needed.
//
`default_nettype none

module stepper_trapezoid_ramp #(
    parameter int STEP_BITS   = 24,
    parameter int PERIOD_BITS = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,

    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic                                    s_kind,
    input  wire logic signed [stpr_pkg::MOVE_W-1:0]      s_move_steps,

    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic                                         m_step_pulse,
    output logic                                         m_direction,
    output logic [stpr_pkg::OUT_PERIOD_W-1:0]            m_next_period,
    output logic                                         m_moving,
    output logic                                         m_finished,

    input  wire logic                                    cfg_wr_en,
    input  wire logic [stpr_pkg::CFG_IDX_W-1:0]          cfg_wr_index,
    input  wire logic [stpr_pkg::CFG_DATA_W-1:0]         cfg_wr_data
);

    localparam int SB   = STEP_BITS;
    localparam int PB   = PERIOD_BITS;
    localparam int WM   = stpr_pkg::MULT_W + 2 * PB;
    localparam int WP   = WM + PB;
    localparam int WX   = (WP > stpr_pkg::DELTA_SHIFT + PB) ? WP
                                                            : stpr_pkg::DELTA_SHIFT + PB + 1;
    localparam int CW   = ((stpr_pkg::MOVE_W > SB) ? stpr_pkg::MOVE_W : SB) + 1;
    localparam int PCW  = ((stpr_pkg::START_PER_W > PB) ? stpr_pkg::START_PER_W : PB) + 1;
    localparam int EW   = (PB > stpr_pkg::OUT_PERIOD_W) ? PB : stpr_pkg::OUT_PERIOD_W;
    localparam int CNTW = $clog2(PB);

    // configuration
    logic [stpr_pkg::RAMP_MAX_W-1:0]  ramp_max_reg;
    logic [stpr_pkg::MULT_W-1:0]      mult_reg;
    logic [stpr_pkg::START_PER_W-1:0] start_per_reg;
    logic                             dir_inv_reg;

    // axis state
    logic [SB-1:0] goal_reg;
    logic [SB-1:0] done_reg;
    logic [SB-1:0] ramp_reg;
    logic [PB-1:0] period_reg;
    logic          busy_reg;
    logic          dir_reg;

    // transaction and control
    stpr_pkg::state_t state_reg, state_next;
    logic                              kind_reg;
    logic signed [stpr_pkg::MOVE_W-1:0] move_reg;
    logic                              decel_reg;
    logic                              res_pulse_reg;
    logic                              res_fin_reg;
    logic                              res_load_reg;

    // multiplier
    logic [WM-1:0]   mcand_reg;
    logic [WM-1:0]   acc_reg;
    logic [PB-1:0]   lo_reg;
    logic [CNTW-1:0] cnt_reg;

    logic m_valid_reg;

    // start decode
    logic                        neg;
    logic [stpr_pkg::MOVE_W-1:0] move_u;
    logic [stpr_pkg::MOVE_W-1:0] mag_raw;
    logic [CW-1:0]               mag_x;
    logic [CW-1:0]               rmax_x;
    logic [CW-1:0]               step_max_x;
    logic [SB-1:0]               mag_sat;
    logic [SB-1:0]               rmax_sat;
    logic [SB-1:0]               half_mag;
    logic [SB-1:0]               ramp_start;
    logic                        dir_start;
    logic [PCW-1:0]              sp_x;
    logic [PCW-1:0]              per_max_x;
    logic [PB-1:0]               sp_sat;

    // tick decode
    logic [SB-1:0] done_inc;
    logic          decel_hit;
    logic          accel_hit;
    logic          calc_mul;

    // multiplier datapath
    logic [WM-1:0] pp;
    logic [WM:0]   sum;
    logic [WP-1:0] prod_next;
    logic          mul_last;

    // period update
    logic [WX-1:0] prod_x;
    logic [WX-1:0] dsh;
    logic [PB-1:0] delta;
    logic [PB:0]   per_sum;
    logic [PB-1:0] per_up;
    logic [PB-1:0] per_down;
    logic [EW-1:0] per_e;

    logic out_load;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    always_comb begin
        neg        = move_reg[stpr_pkg::MOVE_W-1];
        move_u     = $unsigned(move_reg);
        mag_raw    = neg ? (~move_u + stpr_pkg::MOVE_W'(1)) : move_u;
        mag_x      = CW'(mag_raw);
        rmax_x     = CW'(ramp_max_reg);
        step_max_x = CW'({SB{1'b1}});
        mag_sat    = (mag_x > step_max_x) ? {SB{1'b1}} : mag_x[SB-1:0];
        rmax_sat   = (rmax_x > step_max_x) ? {SB{1'b1}} : rmax_x[SB-1:0];
        half_mag   = mag_sat >> 1;
        ramp_start = (rmax_sat > half_mag) ? half_mag : rmax_sat;
        dir_start  = (!neg && (mag_raw != '0)) ? dir_inv_reg : ~dir_inv_reg;
        sp_x       = PCW'(start_per_reg);
        per_max_x  = PCW'({PB{1'b1}});
        if (start_per_reg == '0) begin
            sp_sat = PB'(1);
        end else if (sp_x > per_max_x) begin
            sp_sat = {PB{1'b1}};
        end else begin
            sp_sat = sp_x[PB-1:0];
        end
    end

    always_comb begin
        done_inc  = done_reg + SB'(1);
        decel_hit = (done_inc >= (goal_reg - ramp_reg));
        accel_hit = (done_inc < ramp_reg);
        calc_mul  = (kind_reg == stpr_pkg::KIND_TICK) && busy_reg &&
                    (done_reg < goal_reg) && (decel_hit || accel_hit);
    end

    always_comb begin
        pp        = lo_reg[0] ? mcand_reg : '0;
        sum       = {1'b0, acc_reg} + {1'b0, pp};
        prod_next = {sum, lo_reg[PB-1:1]};
        mul_last  = (cnt_reg == CNTW'(PB - 1));
    end

    always_comb begin
        prod_x   = WX'({acc_reg, lo_reg});
        dsh      = prod_x >> stpr_pkg::DELTA_SHIFT;
        delta    = (|dsh[WX-1:PB]) ? {PB{1'b1}} : dsh[PB-1:0];
        per_sum  = {1'b0, period_reg} + {1'b0, delta};
        per_up   = per_sum[PB] ? {PB{1'b1}} : per_sum[PB-1:0];
        per_down = (delta >= period_reg) ? PB'(1) : (period_reg - delta);
        per_e    = EW'(period_reg);
    end

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stpr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = stpr_pkg::ST_CALC;
                end
            end
            stpr_pkg::ST_CALC: begin
                state_next = calc_mul ? stpr_pkg::ST_MUL1 : stpr_pkg::ST_EMIT;
            end
            stpr_pkg::ST_MUL1: begin
                if (mul_last) begin
                    state_next = stpr_pkg::ST_MUL2;
                end
            end
            stpr_pkg::ST_MUL2: begin
                if (mul_last) begin
                    state_next = stpr_pkg::ST_MUL3;
                end
            end
            stpr_pkg::ST_MUL3: begin
                if (mul_last) begin
                    state_next = stpr_pkg::ST_APPLY;
                end
            end
            stpr_pkg::ST_APPLY: begin
                state_next = stpr_pkg::ST_EMIT;
            end
            stpr_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = stpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == stpr_pkg::ST_IDLE);
        out_load = (state_reg == stpr_pkg::ST_EMIT) && (!m_valid_reg || m_ready);
    end

    // ------------------------------------------------------------------
    // Control and axis state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= stpr_pkg::ST_IDLE;
            ramp_max_reg  <= '0;
            mult_reg      <= '0;
            start_per_reg <= stpr_pkg::START_PER_W'(1);
            dir_inv_reg   <= 1'b0;
            goal_reg      <= '0;
            done_reg      <= '0;
            ramp_reg      <= '0;
            period_reg    <= '0;
            busy_reg      <= 1'b0;
            dir_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            res_pulse_reg <= 1'b0;
            res_fin_reg   <= 1'b0;
            res_load_reg  <= 1'b0;
            decel_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    stpr_pkg::REG_RAMP_STEPS_MAX:
                        ramp_max_reg <= cfg_wr_data[stpr_pkg::RAMP_MAX_W-1:0];
                    stpr_pkg::REG_RAMP_MULTIPLIER:
                        mult_reg <= cfg_wr_data[stpr_pkg::MULT_W-1:0];
                    stpr_pkg::REG_START_PERIOD:
                        start_per_reg <= cfg_wr_data[stpr_pkg::START_PER_W-1:0];
                    stpr_pkg::REG_DIR_INVERT:
                        dir_inv_reg <= cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end

            if (state_reg == stpr_pkg::ST_CALC) begin
                res_pulse_reg <= 1'b0;
                res_fin_reg   <= 1'b0;
                res_load_reg  <= 1'b0;
                decel_reg     <= decel_hit;
                if (kind_reg == stpr_pkg::KIND_START) begin
                    dir_reg      <= dir_start;
                    goal_reg     <= mag_sat;
                    ramp_reg     <= ramp_start;
                    period_reg   <= sp_sat;
                    done_reg     <= '0;
                    busy_reg     <= 1'b1;
                    res_load_reg <= 1'b1;
                end else if (busy_reg) begin
                    if (done_reg < goal_reg) begin
                        done_reg      <= done_inc;
                        res_pulse_reg <= 1'b1;
                        res_load_reg  <= 1'b1;
                    end else begin
                        busy_reg    <= 1'b0;
                        done_reg    <= '0;
                        res_fin_reg <= 1'b1;
                    end
                end
            end

            if (state_reg == stpr_pkg::ST_APPLY) begin
                period_reg <= decel_reg ? per_up : per_down;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload: input capture, multiplier, result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_kind;
            move_reg <= s_move_steps;
        end

        unique case (state_reg)
            stpr_pkg::ST_CALC: begin
                mcand_reg <= WM'(mult_reg);
                acc_reg   <= '0;
                lo_reg    <= period_reg;
                cnt_reg   <= '0;
            end
            stpr_pkg::ST_MUL1, stpr_pkg::ST_MUL2: begin
                if (mul_last) begin
                    mcand_reg <= prod_next[WM-1:0];
                    acc_reg   <= '0;
                    lo_reg    <= period_reg;
                    cnt_reg   <= '0;
                end else begin
                    acc_reg <= sum[WM:1];
                    lo_reg  <= {sum[0], lo_reg[PB-1:1]};
                    cnt_reg <= cnt_reg + CNTW'(1);
                end
            end
            stpr_pkg::ST_MUL3: begin
                acc_reg <= sum[WM:1];
                lo_reg  <= {sum[0], lo_reg[PB-1:1]};
                cnt_reg <= cnt_reg + CNTW'(1);
            end
            default: begin
            end
        endcase

        if (out_load) begin
            m_step_pulse  <= res_pulse_reg;
            m_direction   <= dir_reg;
            m_next_period <= res_load_reg ? per_e[stpr_pkg::OUT_PERIOD_W-1:0] : '0;
            m_moving      <= busy_reg;
            m_finished    <= res_fin_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: tb/stepper_trapezoid_ramp_tb.sv
// ============================================================================
// stepper_trapezoid_ramp_tb
// Self-checking bench for the stepper ramp axis. Start and tick transactions
// are driven under random flow control on both channels. A local model of the
// axis (move bookkeeping plus the exact M*P^3 / 2^80 period update) predicts
// every result, and each result is compared field by field with the oldest
// prediction.
// ============================================================================

module stepper_trapezoid_ramp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] STEP_LIMIT   = 24'hFFFFFF;
    localparam logic [31:0] PERIOD_LIMIT = 32'hFFFFFFFF;
    localparam int          RAMP_LATENCY = 3 * 32 + 4;

    typedef struct packed {
        logic        step_pulse;
        logic        direction;
        logic [31:0] next_period;
        logic        moving;
        logic        finished;
    } ramp_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic                              s_kind       = stpr_pkg::KIND_TICK;
    logic [stpr_pkg::MOVE_W-1:0]       s_move_steps = '0;

    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic                              m_step_pulse;
    logic                              m_direction;
    logic [stpr_pkg::OUT_PERIOD_W-1:0] m_next_period;
    logic                              m_moving;
    logic                              m_finished;

    logic                              cfg_wr_en    = 1'b0;
    logic [stpr_pkg::CFG_IDX_W-1:0]    cfg_wr_index = '0;
    logic [stpr_pkg::CFG_DATA_W-1:0]   cfg_wr_data  = '0;

    // axis model: configuration and move state
    logic [23:0] cfg_ramp_max  = '0;
    logic [31:0] cfg_mult      = '0;
    logic [31:0] cfg_start_per = 32'd1;
    logic        cfg_invert    = 1'b0;
    logic [23:0] goal_cnt      = '0;
    logic [23:0] done_cnt      = '0;
    logic [23:0] ramp_len      = '0;
    logic [31:0] cur_period    = '0;
    logic        axis_busy     = 1'b0;
    logic        dir_pin       = 1'b0;

    ramp_result_t pending_results[$];
    ramp_result_t seen_result;
    ramp_result_t want_result;

    int  mismatch_count = 0;
    int  items_sent     = 0;
    bit  idle_en        = 1'b1;
    int  hold_len       = 0;
    int  hold_seq       = 0;
    int  hold_seen      = 0;
    int  hold_left      = 0;

    stepper_trapezoid_ramp uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_move_steps  (s_move_steps),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_step_pulse  (m_step_pulse),
        .m_direction   (m_direction),
        .m_next_period (m_next_period),
        .m_moving      (m_moving),
        .m_finished    (m_finished),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // floor(M * P^3 / 2^80), saturated to the period range
    function automatic logic [31:0] period_delta(input logic [31:0] p, input logic [31:0] m);
        logic [127:0] prod;
        prod = 128'(m) * 128'(p) * 128'(p) * 128'(p);
        return (prod[127:112] != '0) ? PERIOD_LIMIT : prod[111:80];
    endfunction

    function automatic ramp_result_t advance_axis(input logic kind,
                                                  input logic [stpr_pkg::MOVE_W-1:0] steps);
        ramp_result_t                r;
        logic [stpr_pkg::MOVE_W-1:0] mag_raw;
        logic [23:0]                 mag;
        logic [31:0]                 d;
        logic [32:0]                 sum;
        r = '0;
        if (kind == stpr_pkg::KIND_START) begin
            mag_raw    = steps[stpr_pkg::MOVE_W-1] ? -steps : steps;
            mag        = mag_raw[24] ? STEP_LIMIT : mag_raw[23:0];
            dir_pin    = (!steps[stpr_pkg::MOVE_W-1] && mag != '0) ? cfg_invert : ~cfg_invert;
            goal_cnt   = mag;
            ramp_len   = (cfg_ramp_max > (mag >> 1)) ? (mag >> 1) : cfg_ramp_max;
            cur_period = (cfg_start_per == '0) ? 32'd1 : cfg_start_per;
            done_cnt   = '0;
            axis_busy  = 1'b1;
            r.next_period = cur_period;
        end else if (axis_busy) begin
            if (done_cnt < goal_cnt) begin
                done_cnt     = done_cnt + 1'b1;
                r.step_pulse = 1'b1;
                if (done_cnt >= goal_cnt - ramp_len) begin
                    sum        = {1'b0, cur_period} + period_delta(cur_period, cfg_mult);
                    cur_period = sum[32] ? PERIOD_LIMIT : sum[31:0];
                end else if (done_cnt < ramp_len) begin
                    d          = period_delta(cur_period, cfg_mult);
                    cur_period = (d >= cur_period) ? 32'd1 : cur_period - d;
                end
                r.next_period = cur_period;
            end else begin
                axis_busy  = 1'b0;
                done_cnt   = '0;
                r.finished = 1'b1;
            end
        end
        r.direction = dir_pin;
        r.moving    = axis_busy;
        return r;
    endfunction

    function automatic string show_result(input ramp_result_t r);
        return $sformatf("pulse=%0b dir=%0b period=%08h moving=%0b finished=%0b",
                         r.step_pulse, r.direction, r.next_period, r.moving, r.finished);
    endfunction

    function void log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result = '{m_step_pulse, m_direction, m_next_period, m_moving, m_finished};
            if (pending_results.size() == 0) begin
                log_failure($sformatf("unexpected result: %s", show_result(seen_result)));
            end else begin
                want_result = pending_results.pop_front();
                if (seen_result !== want_result)
                    log_failure($sformatf("mismatch: expected %s, got %s",
                                          show_result(want_result), show_result(seen_result)));
            end
        end
    end

    // result-side flow control, with an optional long hold-off
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !(idle_en && $urandom_range(0, 99) < 30);
        end
    end

    task automatic send_item(input logic kind, input logic [stpr_pkg::MOVE_W-1:0] steps);
        while (idle_en && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_move_steps <= steps;
        do @(posedge aclk); while (!s_ready);
        if (kind == stpr_pkg::KIND_START || axis_busy)
            items_sent++;
        pending_results.push_back(advance_axis(kind, steps));
    endtask

    task automatic drain(input int settle);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_config(input logic [23:0] rmax, input logic [31:0] mult,
                                input logic [31:0] sp, input logic inv);
        logic [stpr_pkg::CFG_DATA_W-1:0] vals[4];
        logic [stpr_pkg::CFG_IDX_W-1:0]  regs[4];
        vals = '{{8'($urandom), rmax}, mult, sp, {31'($urandom), inv}};
        regs = '{stpr_pkg::REG_RAMP_STEPS_MAX, stpr_pkg::REG_RAMP_MULTIPLIER,
                 stpr_pkg::REG_START_PERIOD, stpr_pkg::REG_DIR_INVERT};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= regs[i];
            cfg_wr_data  <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en     <= 1'b0;
        cfg_ramp_max  = rmax;
        cfg_mult      = mult;
        cfg_start_per = sp;
        cfg_invert    = inv;
    endtask

    function automatic logic [stpr_pkg::MOVE_W-1:0] signed_steps(input int unsigned mag,
                                                                 input bit neg);
        logic [stpr_pkg::MOVE_W-1:0] v;
        v = stpr_pkg::MOVE_W'(mag);
        return neg ? -v : v;
    endfunction

    function automatic logic [stpr_pkg::MOVE_W-1:0] any_steps();
        return stpr_pkg::MOVE_W'($urandom);
    endfunction

    task automatic random_move();
        int unsigned mag;
        int          n_ticks;
        case ($urandom_range(0, 9))
            0:       mag = $urandom_range(0, 24'hFFFFFF);
            1:       mag = $urandom_range(41, 2000);
            default: mag = $urandom_range(0, 40);
        endcase
        send_item(stpr_pkg::KIND_START, signed_steps(mag, 1'($urandom_range(0, 1))));
        n_ticks = (mag <= 40) ? mag + 1 : $urandom_range(5, 60);
        if ($urandom_range(0, 9) == 0)
            n_ticks = $urandom_range(0, n_ticks);
        repeat (n_ticks) send_item(stpr_pkg::KIND_TICK, any_steps());
        if ($urandom_range(0, 4) == 0)
            send_item(stpr_pkg::KIND_TICK, any_steps());
    endtask

    task automatic test_reset_state();
        send_item(stpr_pkg::KIND_TICK, any_steps());
        send_item(stpr_pkg::KIND_START, '0);
        send_item(stpr_pkg::KIND_TICK, any_steps());
        send_item(stpr_pkg::KIND_TICK, any_steps());
        send_item(stpr_pkg::KIND_START, signed_steps(3, 1'b0));
        repeat (4) send_item(stpr_pkg::KIND_TICK, any_steps());
        drain(4);
    endtask

    task automatic test_extremes();
        write_config(STEP_LIMIT, PERIOD_LIMIT, PERIOD_LIMIT, 1'b1);
        send_item(stpr_pkg::KIND_START, signed_steps(24'hFFFFFF, 1'b0));
        repeat (2) send_item(stpr_pkg::KIND_TICK, any_steps());
        send_item(stpr_pkg::KIND_START, signed_steps(24'hFFFFFF, 1'b1));
        send_item(stpr_pkg::KIND_TICK, any_steps());
        send_item(stpr_pkg::KIND_START, signed_steps(2, 1'b0));
        repeat (2) send_item(stpr_pkg::KIND_TICK, any_steps());
        send_item(stpr_pkg::KIND_START, signed_steps(4, 1'b0));
        repeat (2) send_item(stpr_pkg::KIND_TICK, any_steps());
        drain(4);
        write_config('0, 32'h0000_0100, '0, 1'b0);
        send_item(stpr_pkg::KIND_START, signed_steps(1, 1'b1));
        repeat (2) send_item(stpr_pkg::KIND_TICK, any_steps());
        drain(4);
    endtask

    task automatic test_backpressure();
        write_config(24'd8, 32'h1000_0000, 32'h0400_0000, 1'b0);
        hold_len = 300;
        hold_seq++;
        send_item(stpr_pkg::KIND_START, signed_steps(20, 1'b0));
        repeat (21) send_item(stpr_pkg::KIND_TICK, any_steps());
        drain(4);
    endtask

    task automatic test_random_traffic();
        int phase_base;
        for (int phase = 0; phase < 10; phase++) begin
            drain(4);
            if (phase == 0)
                write_config('0, '0, '0, 1'b0);
            else if (phase == 1)
                write_config(STEP_LIMIT, PERIOD_LIMIT, PERIOD_LIMIT, 1'b1);
            else
                write_config($urandom_range(0, 1) ? 24'($urandom_range(0, 40)) : 24'($urandom),
                             $urandom >> $urandom_range(0, 31),
                             $urandom >> $urandom_range(0, 31),
                             1'($urandom_range(0, 1)));
            idle_en    = (phase != 4);
            phase_base = items_sent;
            while (items_sent - phase_base < 100) begin
                if ($urandom_range(0, 99) < 85)
                    random_move();
                else if ($urandom_range(0, 1))
                    send_item(stpr_pkg::KIND_TICK, any_steps());
                else
                    send_item(stpr_pkg::KIND_START,
                              signed_steps($urandom_range(0, 24'hFFFFFF),
                                           1'($urandom_range(0, 1))));
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_extremes();
        test_backpressure();
        test_random_traffic();
        drain(RAMP_LATENCY + 10);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
